[hw/rtl/dtq_pkg.sv]
package dtq_pkg;

  localparam int QueueDepth = 32;
  localparam int SlotBits   = $clog2(QueueDepth);
  localparam int IdBits     = 16;
  localparam int TimeBits   = 32;
  localparam int DurBits    = 28;
  localparam int SecsPerMin = 60;
  localparam int SecsPerHr  = SecsPerMin * SecsPerMin;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_RETIME = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUR,
    S_SCAN,
    S_ACT,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture the request and clear the scan result
    logic    dur_step;   // register the duration products
    logic    scan_clr;   // clear best slot before a scan
    logic    scan_en;    // examine the slot under the scan index
    logic    commit;     // apply the operation to the chosen slot
    logic    out_load;   // load the result register
    status_e out_status;
    logic    out_use_id; // 0: id 0, 1: id from the datapath
    logic    out_last;
  } dtq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic scan_done;
    logic found;
    logic any_valid;
    logic any_free;
    logic single_exp;    // the last scan saw exactly one expired timer
  } dtq_sts_t;

  // True when a is before b as a wrapping signed difference.
  function automatic logic time_before(logic [TimeBits-1:0] a, logic [TimeBits-1:0] b);
    logic [TimeBits-1:0] d;
    d = a - b;
    return d[TimeBits-1];
  endfunction

endpackage

[hw/rtl/dtq_datapath.sv]
module dtq_datapath import dtq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtq_cmd_t             cmd_i,
  output dtq_sts_t             sts_o,
  input  logic [1:0]           operation_i,
  input  logic [15:0]          timer_id_i,
  input  logic signed [15:0]   add_seconds_i,
  input  logic signed [15:0]   add_minutes_i,
  input  logic signed [15:0]   add_hours_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [15:0]          result_id_o,
  output logic                 last_o
);

  logic [QueueDepth-1:0]  valid_q, valid_d;
  logic [IdBits-1:0]      id_q [QueueDepth];
  logic [TimeBits-1:0]    dl_q [QueueDepth];
  logic [TimeBits-1:0]    now_q, now_d;
  logic [IdBits-1:0]      next_q, next_d;

  op_e                    op_q;
  logic [IdBits-1:0]      req_id_q;
  logic signed [15:0]     sec_q, min_q, hr_q;
  logic signed [DurBits-1:0] pmin_q, phr_q;
  logic [TimeBits-1:0]    end_q;

  logic [SlotBits:0]      idx_q;
  logic                   found_q;
  logic [SlotBits-1:0]    best_q;
  logic                   free_found_q;
  logic [SlotBits-1:0]    free_q;

  logic                   ovalid_q;
  logic [2:0]             ostat_q;
  logic [15:0]            oid_q;
  logic                   olast_q;

  logic [SlotBits-1:0]    idx;
  logic                   cand, better;
  logic [IdBits-1:0]      next_inc;
  logic [IdBits-1:0]      new_id;
  logic signed [DurBits-1:0] dur;
  logic                   single_exp;

  assign idx      = idx_q[SlotBits-1:0];
  assign dur      = DurBits'(sec_q) + pmin_q + phr_q;
  assign next_inc = next_q + IdBits'(1);
  assign new_id   = (next_inc == '0) ? IdBits'(1) : next_inc;

  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    if (valid_q[idx]) begin
      if (op_q == OP_TICK) begin
        cand = !time_before(now_q, dl_q[idx]);
        if (found_q) begin
          better = time_before(dl_q[idx], dl_q[best_q]) ||
                   (!time_before(dl_q[best_q], dl_q[idx]) && id_q[idx] < id_q[best_q]);
        end
      end else begin
        cand = (id_q[idx] == req_id_q);
        if (found_q) begin
          better = time_before(dl_q[idx], dl_q[best_q]);
        end
      end
    end
    if (!found_q) begin
      better = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    now_d   = now_q;
    next_d  = next_q;
    if (cmd_i.load && operation_i == OP_TICK) begin
      now_d = now_q + 1'b1;
    end
    if (cmd_i.commit) begin
      case (op_q)
        OP_ADD: begin
          valid_d[free_q] = 1'b1;
          next_d = new_id;
        end
        OP_RETIME: ;
        OP_CANCEL, OP_TICK: valid_d[best_q] = 1'b0;
        default: ;
      endcase
    end
  end

  // Expired timers seen by the current tick scan.
  dtq_tick u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (cmd_i.scan_clr || cmd_i.load),
    .hit_i    (cmd_i.scan_en && op_q == OP_TICK && cand),
    .single_o (single_exp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      now_q    <= '0;
      next_q   <= '0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      best_q   <= '0;
      free_found_q <= 1'b0;
      free_q   <= '0;
    end else begin
      valid_q <= valid_d;
      now_q   <= now_d;
      next_q  <= next_d;
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.scan_clr || cmd_i.load) begin
        idx_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan_en) begin
        idx_q <= idx_q + 1'b1;
        if (cand && better) begin
          found_q <= 1'b1;
          best_q  <= idx;
        end
        if (!valid_q[idx] && !free_found_q) begin
          free_found_q <= 1'b1;
          free_q       <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(operation_i);
      req_id_q <= timer_id_i[IdBits-1:0];
      sec_q    <= add_seconds_i;
      min_q    <= add_minutes_i;
      hr_q     <= add_hours_i;
    end
    if (cmd_i.dur_step) begin
      pmin_q <= DurBits'(min_q) * DurBits'(SecsPerMin);
      phr_q  <= DurBits'(hr_q) * DurBits'(SecsPerHr);
    end
    if (cmd_i.scan_clr) begin
      end_q <= now_q + TimeBits'(dur);
    end
    if (cmd_i.commit) begin
      case (op_q)
        OP_ADD: begin
          id_q[free_q] <= new_id;
          dl_q[free_q] <= end_q;
        end
        OP_RETIME: dl_q[best_q] <= end_q;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      ostat_q <= cmd_i.out_status;
      olast_q <= cmd_i.out_last;
      if (!cmd_i.out_use_id) begin
        oid_q <= '0;
      end else if (op_q == OP_ADD) begin
        oid_q <= new_id;
      end else if (op_q == OP_TICK) begin
        oid_q <= id_q[best_q];
      end else begin
        oid_q <= req_id_q;
      end
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.scan_done  = idx_q == (SlotBits+1)'(QueueDepth);
  assign sts_o.found      = found_q;
  assign sts_o.any_valid  = |valid_q;
  assign sts_o.any_free   = free_found_q;
  assign sts_o.single_exp = single_exp;

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign result_id_o = oid_q;
  assign last_o      = olast_q;

endmodule

[hw/rtl/dtq_ctrl.sv]
module dtq_ctrl import dtq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  dtq_sts_t sts_i,
  output dtq_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_free;

  assign out_free = !out_valid_i || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DUR;
        end
      end
      S_DUR: begin
        cmd_o.dur_step = 1'b1;
        state_d        = S_ACT;
      end
      S_ACT: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.scan_en = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
          case (sts_i.op)
            OP_ADD: begin
              if (sts_i.any_free) begin
                cmd_o.out_status = ST_OK;
                cmd_o.out_use_id = 1'b1;
                cmd_o.commit     = 1'b1;
              end else begin
                cmd_o.out_status = ST_FULL;
              end
            end
            OP_RETIME, OP_CANCEL: begin
              if (!sts_i.any_valid) begin
                cmd_o.out_status = ST_EMPTY;
              end else if (!sts_i.found) begin
                cmd_o.out_status = ST_NOT_FOUND;
                cmd_o.out_use_id = 1'b1;
              end else begin
                cmd_o.out_status = ST_OK;
                cmd_o.out_use_id = 1'b1;
                cmd_o.commit     = 1'b1;
              end
            end
            OP_TICK: begin
              if (sts_i.found) begin
                // Emit and remove the earliest expired timer; rescan while more remain.
                cmd_o.out_status = ST_EXPIRED;
                cmd_o.out_use_id = 1'b1;
                cmd_o.commit     = 1'b1;
                if (!sts_i.single_exp) begin
                  cmd_o.out_last = 1'b0;
                  state_d        = S_ACT;
                end
              end else begin
                cmd_o.out_status = ST_NONE;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/dtq_tick.sv]
module dtq_tick import dtq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clr_i,
  input  logic hit_i,
  output logic single_o
);

  // Counts the expired timers seen in one scan, so that the final timer of a
  // tick can carry last.
  logic [SlotBits:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (clr_i) begin
      cnt_d = '0;
    end else if (hit_i) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign single_o = cnt_q == (SlotBits+1)'(1);

endmodule

[hw/rtl/deadline_timer_queue.sv]
// Channel | Handshake                  | Fields
// in      | in_valid_i / in_stall_o    | operation_i, timer_id_i, add_{seconds,minutes,hours}_i
// out     | out_valid_o / out_stall_i  | status_o, result_id_o, last_o
//
// A request is taken only in idle; a one-result request then passes through the duration
// products (S_DUR), the end time (S_ACT), a walk of the 32 slots one a cycle (S_SCAN), and
// the loading of the result (S_OUT) before the next acceptance.
// A tick emits one expired timer per walk; each further expired timer repeats the end time, walk and load.
// Reset clears all slot valid bits, the seconds counter and the id counter.
// A stalled output holds its result; the block waits in S_OUT while it is stalled before loading more.
module deadline_timer_queue import dtq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] timer_id_i,
  input  logic [15:0] add_seconds_i,
  input  logic [15:0] add_minutes_i,
  input  logic [15:0] add_hours_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic        last_o
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;
  logic     ovalid;

  // The controller sequences each request and drives the datapath by commands.
  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_i (ovalid),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the slots, the counters, the scan unit and the result register.
  dtq_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .timer_id_i    (timer_id_i),
    .add_seconds_i (add_seconds_i),
    .add_minutes_i (add_minutes_i),
    .add_hours_i   (add_hours_i),
    .out_valid_o   (ovalid),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .last_o        (last_o)
  );

  assign out_valid_o = ovalid;

  // A stalled result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
                                   $stable(result_id_o) && $stable(last_o));

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_NONE);

  // Only expired timers can be followed by more results of the same request.
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_EXPIRED |-> last_o);

  // Handshake outputs are always known out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({out_valid_o, in_stall_o}));

endmodule
